// ===== hw/rtl/stl_pkg.sv =====
// Shared types, character codes and helpers for the token lexer.
package stl_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_UP_A  = 8'd65;
    localparam logic [7:0] CH_UP_Z  = 8'd90;
    localparam logic [7:0] CH_LO_A  = 8'd97;
    localparam logic [7:0] CH_LO_Z  = 8'd122;
    localparam logic [7:0] CH_GT    = 8'd62;
    localparam logic [7:0] CH_LT    = 8'd60;
    localparam logic [7:0] CH_EQ    = 8'd61;
    localparam logic [7:0] CH_SPACE = 8'd32;

    typedef enum logic [2:0] {
        KIND_NUM     = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_GE      = 3'd2,
        KIND_LE      = 3'd3,
        KIND_ASSIGN  = 3'd4,
        KIND_INVALID = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_NUM     = 3'd1,
        MODE_IDENT   = 3'd2,
        MODE_CMP     = 3'd3,
        MODE_ASSIGN  = 3'd4,
        MODE_INVALID = 3'd5
    } mode_t;

    typedef struct packed {
        logic [7:0] ch;
        kind_t      kind;
        logic       last;
        logic       run_last;
    } result_t;

    // Results of one accepted character, in order, r0 first.
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    typedef struct packed {
        logic held_valid;
        mode_t mode;
    } core_status_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
    } fifo_status_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
    endfunction

    function automatic result_t mk_result(input logic [7:0] c, input kind_t k,
                                          input logic last);
        result_t r;
        r.ch       = c;
        r.kind     = k;
        r.last     = last;
        r.run_last = 1'b0;
        return r;
    endfunction

endpackage

// ===== hw/rtl/stl_core.sv =====
// Lexer state and per-character classification: one character in, up to two words out.
module stl_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           char_code,
    input  logic                 line_end,
    output stl_pkg::push_t       push,
    output stl_pkg::core_status_t status
);
    import stl_pkg::*;

    mode_t      mode_reg,  mode_next;
    logic [7:0] char_reg,  char_next;
    kind_t      kind_reg,  kind_next;
    logic       valid_reg, valid_next;

    mode_t   mode_eff;
    logic    st_valid;
    kind_t   st_kind;
    mode_t   st_mode;
    logic    go_on;
    kind_t   cmp_kind;
    push_t   p;

    // Token opened by the current character from idle
    always_comb
    begin
        st_valid = 1'b1;
        st_kind  = KIND_INVALID;
        st_mode  = MODE_INVALID;
        priority if (char_code == CH_SPACE)
        begin
            st_valid = 1'b0;
            st_mode  = MODE_IDLE;
        end
        else if (is_digit(char_code))
        begin
            st_kind = KIND_NUM;
            st_mode = MODE_NUM;
        end
        else if (is_letter(char_code))
        begin
            st_kind = KIND_IDENT;
            st_mode = MODE_IDENT;
        end
        else if ((char_code == CH_GT) || (char_code == CH_LT))
        begin
            st_kind = KIND_INVALID;
            st_mode = MODE_CMP;
        end
        else if (char_code == CH_EQ)
        begin
            st_kind = KIND_ASSIGN;
            st_mode = MODE_ASSIGN;
        end
        else
        begin
            // Any other byte opens an invalid token
            st_kind = KIND_INVALID;
            st_mode = MODE_INVALID;
        end
    end

    always_comb
    begin
        mode_eff = valid_reg ? mode_reg : MODE_IDLE;
        cmp_kind = (char_reg == CH_GT) ? KIND_GE : KIND_LE;
        unique case (mode_eff)
            MODE_NUM:   go_on = is_digit(char_code);
            MODE_IDENT: go_on = is_digit(char_code) || is_letter(char_code);
            default:    go_on = (char_code == CH_EQ);
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        char_next  = char_reg;
        kind_next  = kind_reg;
        valid_next = valid_reg;
        p.n  = 2'd0;
        p.r0 = mk_result(char_reg, kind_reg, 1'b0);
        p.r1 = mk_result(char_code, cmp_kind, 1'b1);
        if (fire)
        begin
            mode_next = mode_eff;
            unique case (mode_eff)
                MODE_NUM, MODE_IDENT, MODE_ASSIGN:
                begin
                    p.n = 2'd1;
                    if (go_on)
                    begin
                        p.r0      = mk_result(char_reg, kind_reg, 1'b0);
                        char_next = char_code;
                    end
                    else
                    begin
                        p.r0       = mk_result(char_reg, kind_reg, 1'b1);
                        char_next  = char_code;
                        kind_next  = st_kind;
                        valid_next = st_valid;
                        mode_next  = st_mode;
                    end
                end
                MODE_CMP:
                begin
                    if (char_code == CH_EQ)
                    begin
                        // Sign and '=' leave together as one two-character token
                        p.n        = 2'd2;
                        p.r0       = mk_result(char_reg, cmp_kind, 1'b0);
                        p.r1       = mk_result(char_code, cmp_kind, 1'b1);
                        valid_next = 1'b0;
                        mode_next  = MODE_IDLE;
                    end
                    else
                    begin
                        p.n       = 2'd1;
                        p.r0      = mk_result(char_reg, KIND_INVALID, 1'b0);
                        char_next = char_code;
                        kind_next = KIND_INVALID;
                        mode_next = MODE_INVALID;
                    end
                end
                MODE_INVALID:
                begin
                    p.n       = 2'd1;
                    p.r0      = mk_result(char_reg, KIND_INVALID, 1'b0);
                    char_next = char_code;
                    kind_next = KIND_INVALID;
                end
                default:
                begin
                    char_next  = char_code;
                    kind_next  = st_kind;
                    valid_next = st_valid;
                    mode_next  = st_mode;
                    if (!st_valid)
                    begin
                        char_next = char_reg;
                        kind_next = kind_reg;
                    end
                end
            endcase

            // Flush whatever is held at the end of the line
            if (line_end && valid_next)
            begin
                if (p.n == 2'd0)
                begin
                    p.r0 = mk_result(char_next, kind_next, 1'b1);
                end
                else
                begin
                    p.r1 = mk_result(char_next, kind_next, 1'b1);
                end
                p.n        = p.n + 2'd1;
                valid_next = 1'b0;
            end
            if (line_end)
            begin
                mode_next = MODE_IDLE;
            end

            if (p.n == 2'd1)
            begin
                p.r0.run_last = 1'b1;
            end
            else if (p.n == 2'd2)
            begin
                p.r1.run_last = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            char_reg  <= '0;
            kind_reg  <= KIND_NUM;
            valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            char_reg  <= char_next;
            kind_reg  <= kind_next;
            valid_reg <= valid_next;
        end
    end

    assign push              = p;
    assign status.held_valid = valid_reg;
    assign status.mode       = mode_reg;

endmodule

// ===== hw/rtl/stl_out_fifo.sv =====
// Result queue: takes up to two words per cycle, hands out one.
module stl_out_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stl_pkg::push_t        push,
    input  logic                  pop,
    output stl_pkg::result_t      head,
    output logic                  not_empty,
    output stl_pkg::fifo_status_t status
);
    import stl_pkg::*;

    result_t          entry_reg  [FIFO_DEPTH];
    result_t          entry_next [FIFO_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] base;

    always_comb
    begin
        base       = count_reg - CNT_W'(pop);
        count_next = base + CNT_W'(push.n);
        for (int i = 0; i < FIFO_DEPTH; i++)
        begin
            // Shift down on a pop, then append behind the survivors
            if (CNT_W'(i) < base)
            begin
                entry_next[i] = pop ? entry_reg[PTR_W'(i + 1)] : entry_reg[i];
            end
            else if ((CNT_W'(i) == base) && (push.n != 2'd0))
            begin
                entry_next[i] = push.r0;
            end
            else if ((CNT_W'(i) == base + CNT_W'(1)) && (push.n == 2'd2))
            begin
                entry_next[i] = push.r1;
            end
            else
            begin
                entry_next[i] = entry_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FIFO_DEPTH; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
    end

    assign head         = entry_reg[0];
    assign not_empty    = (count_reg != '0);
    assign status.count = count_reg;

endmodule

// ===== hw/rtl/simple_token_lexer.sv =====
// Streaming lexer top level: character words in, tagged token character words out.
// One character is accepted per cycle while in_ready is high, and the words it causes appear
// at the output from the next cycle on. A character gives zero, one or two output words; the
// output port moves one word per cycle while out_ready is high, so the sustained rate is one
// character per cycle while each gives at most one word, and the '=' of a "<=" or ">=" pair
// gives two words. Words wait in a four-entry queue; in_ready is high while at most two words
// are queued, so input waits only while the output side leaves words standing in the queue.
// The last character of a token is known only from the character after it or from line_end,
// so a token character leaves one character late unless the line ends.
module simple_token_lexer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       line_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic [2:0] token_kind,
    output logic       token_last,
    output logic       run_last
);
    import stl_pkg::*;

    logic         fire;
    logic         pop;
    push_t        push;
    result_t      head;
    core_status_t core_st;
    fifo_status_t fifo_st;

    // Room for two more words must be there before a character is taken
    assign in_ready = (fifo_st.count <= CNT_W'(FIFO_DEPTH - 2));
    assign fire     = in_valid && in_ready;
    assign pop      = out_valid && out_ready;

    stl_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .char_code (char_code),
        .line_end  (line_end),
        .push      (push),
        .status    (core_st)
    );

    stl_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (out_valid),
        .status    (fifo_st)
    );

    assign out_char   = head.ch;
    assign token_kind = head.kind;
    assign token_last = head.last;
    assign run_last   = head.run_last;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_st.count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_line_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
        fire && line_end |=> !core_st.held_valid && (core_st.mode == MODE_IDLE))
        else $error("character still held after line end");

    a_push_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |-> (push.n == 2'd0))
        else $error("words pushed without an accepted character");

    a_pair_ends_token: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd2) |-> push.r1.last && push.r1.run_last && !push.r0.run_last)
        else $error("second word of a pair does not close the run");

endmodule

// ===== dv/tb_simple_token_lexer.sv =====
// Self-checking testbench for the streaming token lexer: directed lines, random lines, stalls.
module tb_simple_token_lexer;
    import stl_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 300;

    typedef struct {
        logic [7:0] ch;
        logic       le;
        bit         drain;
    } char_item_t;

    typedef struct {
        logic [7:0] ch;
        kind_t      kind;
        logic       last;
        logic       run_last;
    } tok_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] char_code = 8'd0;
    logic       line_end = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_char;
    logic [2:0] token_kind;
    logic       token_last;
    logic       run_last;

    char_item_t pending_chars[$];
    tok_word_t  token_words[$];
    bit         mark_drain = 1'b0;
    int         err_count = 0;
    int         chars_taken = 0;

    // Lexer state as the predictor tracks it
    mode_t      lx_mode = MODE_IDLE;
    logic [7:0] lx_char = 8'd0;
    kind_t      lx_kind = KIND_NUM;
    logic       lx_held = 1'b0;

    wire in_fire  = in_valid && in_ready;
    wire out_fire = out_valid && out_ready;

    simple_token_lexer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .line_end   (line_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .token_kind (token_kind),
        .token_last (token_last),
        .run_last   (run_last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit ch_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit ch_alpha(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction

    function automatic logic [7:0] rand_alpha();
        if ($urandom_range(0, 1) == 0)
            return 8'(CH_UP_A + $urandom_range(0, 25));
        return 8'(CH_LO_A + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    task automatic flag_error(input string msg);
        if (err_count < 10)
            $display("%s", msg);
        err_count++;
    endtask

    task automatic emit_word(input logic [7:0] c, input kind_t k, input logic last);
        tok_word_t w;
        w.ch       = c;
        w.kind     = k;
        w.last     = last;
        w.run_last = 1'b0;
        token_words.push_back(w);
    endtask

    task automatic hold_char(input logic [7:0] c, input kind_t k, input mode_t m);
        lx_char = c;
        lx_kind = k;
        lx_held = 1'b1;
        lx_mode = m;
    endtask

    // Open a token from idle; a space opens nothing
    task automatic open_token(input logic [7:0] c);
        lx_held = 1'b0;
        lx_mode = MODE_IDLE;
        if (c == CH_SPACE)
            return;
        if (ch_digit(c))
            hold_char(c, KIND_NUM, MODE_NUM);
        else if (ch_alpha(c))
            hold_char(c, KIND_IDENT, MODE_IDENT);
        else if (c == CH_GT || c == CH_LT)
            hold_char(c, KIND_INVALID, MODE_CMP);
        else if (c == CH_EQ)
            hold_char(c, KIND_ASSIGN, MODE_ASSIGN);
        else
            hold_char(c, KIND_INVALID, MODE_INVALID);
    endtask

    task automatic lex_predict(input logic [7:0] c, input logic le);
        int    before_n;
        bit    cont;
        kind_t cmp_kind;
        before_n = token_words.size();
        if (!lx_held)
            lx_mode = MODE_IDLE;
        case (lx_mode)
            MODE_NUM, MODE_IDENT, MODE_ASSIGN:
            begin
                if (lx_mode == MODE_NUM)
                    cont = ch_digit(c);
                else if (lx_mode == MODE_IDENT)
                    cont = ch_digit(c) || ch_alpha(c);
                else
                    cont = (c == CH_EQ);
                if (cont)
                begin
                    emit_word(lx_char, lx_kind, 1'b0);
                    lx_char = c;
                end
                else
                begin
                    emit_word(lx_char, lx_kind, 1'b1);
                    open_token(c);
                end
            end
            MODE_CMP:
            begin
                if (c == CH_EQ)
                begin
                    cmp_kind = (lx_char == CH_GT) ? KIND_GE : KIND_LE;
                    emit_word(lx_char, cmp_kind, 1'b0);
                    emit_word(c, cmp_kind, 1'b1);
                    lx_held = 1'b0;
                    lx_mode = MODE_IDLE;
                end
                else
                begin
                    emit_word(lx_char, KIND_INVALID, 1'b0);
                    hold_char(c, KIND_INVALID, MODE_INVALID);
                end
            end
            MODE_INVALID:
            begin
                emit_word(lx_char, KIND_INVALID, 1'b0);
                lx_char = c;
                lx_kind = KIND_INVALID;
            end
            default:
                open_token(c);
        endcase
        // Line end flushes whatever is held
        if (le && lx_held)
        begin
            emit_word(lx_char, lx_kind, 1'b1);
            lx_held = 1'b0;
        end
        if (le)
            lx_mode = MODE_IDLE;
        if (token_words.size() > before_n)
            token_words[token_words.size() - 1].run_last = 1'b1;
    endtask

    task automatic add_char(input logic [7:0] c, input logic le);
        char_item_t it;
        it.ch      = c;
        it.le      = le;
        it.drain   = mark_drain;
        mark_drain = 1'b0;
        pending_chars.push_back(it);
    endtask

    task automatic add_line(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(8'(s[i]), i == s.len() - 1);
    endtask

    // Mostly well-formed lines with random content; a few carry stray bytes and lone signs
    task automatic gen_line();
        logic [7:0] chars[$];
        int         ntok;
        int         sep;
        bit         noisy;
        noisy = ($urandom_range(0, 7) == 0);
        ntok  = $urandom_range(1, 6);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) chars.push_back(CH_SPACE);
        for (int t = 0; t < ntok; t++)
        begin
            case ($urandom_range(0, 5))
                0: repeat ($urandom_range(1, 4)) chars.push_back(rand_digit());
                1:
                begin
                    chars.push_back(rand_alpha());
                    repeat ($urandom_range(0, 5))
                        chars.push_back(($urandom_range(0, 2) == 0) ? rand_digit() : rand_alpha());
                end
                2:
                begin
                    chars.push_back(CH_GT);
                    chars.push_back(CH_EQ);
                end
                3:
                begin
                    chars.push_back(CH_LT);
                    chars.push_back(CH_EQ);
                end
                4: repeat ($urandom_range(1, 3)) chars.push_back(CH_EQ);
                default:
                begin
                    if (!noisy)
                        chars.push_back(rand_digit());
                    else if ($urandom_range(0, 2) == 0)
                        chars.push_back(($urandom_range(0, 1) == 0) ? CH_GT : CH_LT);
                    else
                        chars.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            sep = $urandom_range(0, 4);
            if (t < ntok - 1 || $urandom_range(0, 5) == 0)
            begin
                if (sep == 4)
                    repeat (2) chars.push_back(CH_SPACE);
                else if (sep != 0)
                    chars.push_back(CH_SPACE);
            end
        end
        foreach (chars[i])
            add_char(chars[i], i == chars.size() - 1);
    endtask

    // Sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin : char_driver
        int burst_left;
        int gap_left;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            char_code  <= 8'd0;
            line_end   <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (in_fire)
            begin
                lex_predict(char_code, line_end);
                chars_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_chars.size() != 0 &&
                         !(pending_chars[0].drain && token_words.size() != 0))
                begin
                    in_valid  <= 1'b1;
                    char_code <= pending_chars[0].ch;
                    line_end  <= pending_chars[0].le;
                    void'(pending_chars.pop_front());
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall patterns that change over the run, plus long hold-offs mid-run
    always @(posedge clk or negedge rst_n)
    begin : word_sink
        int phase;
        int rx_mode;
        int hold_left;
        int holds_done;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            phase      = 0;
            rx_mode    = 0;
            hold_left  = 0;
            holds_done = 0;
        end
        else
        begin
            phase++;
            if (phase % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            if (hold_left == 0 && holds_done < 2 && chars_taken >= 400 * (holds_done + 1))
            begin
                hold_left = HOLD_LEN;
                holds_done++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 0);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (phase % 5) < 3;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : word_check
        tok_word_t want;
        if (rst_n && out_fire)
        begin
            if (token_words.size() == 0)
                flag_error($sformatf("unexpected word: char %0d kind %0d last %0b run_last %0b",
                                     out_char, token_kind, token_last, run_last));
            else
            begin
                want = token_words.pop_front();
                if (out_char !== want.ch || token_kind !== 3'(want.kind) ||
                    token_last !== want.last || run_last !== want.run_last)
                    flag_error($sformatf(
                        "mismatch: want char %0d kind %0d last %0b rl %0b, got %0d %0d %0b %0b",
                        want.ch, want.kind, want.last, want.run_last,
                        out_char, token_kind, token_last, run_last));
            end
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (in_fire || out_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simple_token_lexer verification failed");
        $finish;
    end

    initial
    begin
        // Directed lines: field extremes, every token kind and the corner cases
        add_line("9A0 z");
        add_line("Za>=<=");
        add_line(">==<");
        add_line("<a b");
        add_line(" ");
        add_char(8'h00, 1'b0);
        add_char(8'hff, 1'b0);
        add_char(8'h09, 1'b1);
        // Hold the first random character until every directed word has come back
        mark_drain = 1'b1;
        while (pending_chars.size() < 1050)
        begin
            if (pending_chars.size() > 600 && pending_chars.size() < 640)
                mark_drain = 1'b1;
            gen_line();
        end

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        while (pending_chars.size() != 0 || in_valid || token_words.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        if (token_words.size() != 0)
            flag_error($sformatf("%0d expected words never arrived", token_words.size()));
        if (err_count == 0)
            $display("simple_token_lexer verification clean");
        else
            $display("simple_token_lexer verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/stl_pkg.sv
hw/rtl/stl_core.sv
hw/rtl/stl_out_fifo.sv
hw/rtl/simple_token_lexer.sv
dv/tb_simple_token_lexer.sv
